// ===== sv/weekly_scheduled_relay_macros.svh =====
// Assertion macros shared by the weekly scheduled relay modules.
`ifndef WEEKLY_SCHEDULED_RELAY_MACROS_SVH
`define WEEKLY_SCHEDULED_RELAY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/wsr_pkg.sv =====
// Types, constants and register indexes of the weekly scheduled relay.
package wsr_pkg;

    localparam int NUM_EVENTS  = 4;
    localparam int EVENT_REGS  = 4;
    localparam int SEC_W       = 17;
    localparam int END_W       = SEC_W + 1;
    localparam int EVENT_W     = 41;
    localparam int CNT_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = EVENT_W;
    localparam int DAY_SECONDS = 86400;

    localparam logic [CFG_IDX_W-1:0] REG_EVENT_A     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FOLLOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SUSPEND     = 3'd6;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_ON     = 2'd1,
        CMD_OFF    = 2'd2,
        CMD_TOGGLE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_KEEP   = 2'd0,
        OP_SET    = 2'd1,
        OP_INVERT = 2'd2
    } op_t;

    typedef struct packed {
        logic             tick;
        logic [SEC_W-1:0] now;
        logic [2:0]       day;
        logic             dep;
        op_t              op;
        logic             val;
    } stage_t;

    typedef struct packed {
        logic enable;
        logic follow;
    } cell_ctl_t;

endpackage

// ===== sv/wsr_in_if.sv =====
// Input channel: one command word with time, weekday and dependent state.
interface wsr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [16:0] time_of_day;
    logic [2:0]  weekday;
    logic        dependent_on;

    modport source (output valid, command, time_of_day, weekday, dependent_on,
                    input ready);
    modport sink (input valid, command, time_of_day, weekday, dependent_on,
                  output ready);
endinterface

// ===== sv/wsr_out_if.sv =====
// Output channel: one relay level word per accepted input word.
interface wsr_out_if;
    logic valid;
    logic ready;
    logic relay_on;

    modport source (output valid, relay_on, input ready);
    modport sink (input valid, relay_on, output ready);
endinterface

// ===== sv/wsr_cell.sv =====
// One event cell: holds one event and rewrites the relay operation of the word passing by.
`include "weekly_scheduled_relay_macros.svh"

module wsr_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  wsr_pkg::stage_t               in_stage,
    output logic                          out_valid,
    input  logic                          out_ready,
    output wsr_pkg::stage_t               out_stage,
    input  logic                          ev_we,
    input  logic [wsr_pkg::EVENT_W-1:0]   ev_data,
    input  wsr_pkg::cell_ctl_t            ctl
);
    import wsr_pkg::*;

    logic [EVENT_W-1:0] event_reg;
    logic               valid_reg;
    logic               valid_next;
    stage_t             stage_reg;
    stage_t             stage_next;

    logic [SEC_W-1:0] start_sec;
    logic [SEC_W-1:0] dur_sec;
    logic [7:0]       day_mask;
    logic [END_W-1:0] end_sum;
    logic [END_W-1:0] end_sec;
    logic [END_W-1:0] now_ext;
    logic             wrapped;
    logic             in_window;
    logic             active;

    assign start_sec = event_reg[16:0];
    assign dur_sec   = event_reg[33:17];
    assign day_mask  = {1'b0, event_reg[40:34]};
    assign end_sum   = {1'b0, start_sec} + {1'b0, dur_sec};
    assign wrapped   = end_sum >= END_W'(DAY_SECONDS);
    assign end_sec   = wrapped ? end_sum - END_W'(DAY_SECONDS) : end_sum;
    assign now_ext   = {1'b0, in_stage.now};
    assign active    = in_stage.tick && ctl.enable && day_mask[in_stage.day];

    always_comb
    begin
        if (wrapped)
            in_window = (now_ext >= {1'b0, start_sec}) || (now_ext <= end_sec);
        else
            in_window = (now_ext >= {1'b0, start_sec}) && (now_ext <= end_sec);
    end

    always_comb
    begin
        stage_next = in_stage;
        if (active)
        begin
            if (ctl.follow)
            begin
                stage_next.op  = OP_SET;
                stage_next.val = in_window && in_stage.dep;
            end
            else if (now_ext == {1'b0, start_sec})
            begin
                stage_next.op  = OP_SET;
                stage_next.val = 1'b1;
            end
            else if (now_ext == end_sec)
            begin
                stage_next.op  = OP_SET;
                stage_next.val = 1'b0;
            end
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign out_valid  = valid_reg;
    assign out_stage  = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            event_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ev_we)
                event_reg <= ev_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            stage_reg <= stage_next;
    end

    `WSR_ASSERT_NEXT(a_non_tick_passes, in_valid && in_ready && !in_stage.tick,
        stage_reg.op == $past(in_stage.op) && stage_reg.val == $past(in_stage.val))
    `WSR_ASSERT_NEXT(a_stall_holds, valid_reg && !out_ready,
        valid_reg && $stable(stage_reg))
    `WSR_ASSERT_NOW(a_cell_ready_when_empty, !valid_reg, in_ready)

endmodule

// ===== sv/weekly_scheduled_relay.sv =====
// Top level of the weekly scheduled relay: configuration, event cell chain and relay state.
// Usage:
// The item channel takes one command word per cycle unless the chain is full: tick,
// switch on, switch off or toggle, with time of day, weekday and dependent device state.
// The result channel returns one relay level word for every accepted item, in order.
// The user must write events, event count, follow mode and suspend through the plain
// write port only while idle, which the block does not enforce; index seven is ignored.
// Each item walks a chain of one registered cell per event, and each cell
// rewrites the pending relay operation; the relay state is applied at the end.
// A result is registered in each cell in turn and then in the result register.
// The chain takes one item per cycle while a receiver stall does not hold it up.
// Every cell and the result register have their own handshake, so the input keeps
// accepting items while a finished result waits and the chain still has room.
// When the receiver stalls, results queue in the chain and the input stops only
// once every stage is full.
// Reset clears all registers but the cell stage data, leaves the relay off and the chain empty.
`include "weekly_scheduled_relay_macros.svh"

module weekly_scheduled_relay (
    input  logic                             clk,
    input  logic                             rst_n,
    wsr_in_if.sink                           item,
    wsr_out_if.source                        result,
    input  logic                             write_enable,
    input  logic [wsr_pkg::CFG_IDX_W-1:0]    reg_index,
    input  logic [wsr_pkg::CFG_DATA_W-1:0]   write_data
);
    import wsr_pkg::*;

    logic [2:0]       event_count_reg;
    logic             follow_reg;
    logic             suspend_reg;
    logic             relay_state_reg;
    logic             relay_state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CNT_W-1:0] count_ext;
    logic [CNT_W-1:0] count_sat;

    logic   node_valid [NUM_EVENTS+1];
    logic   node_ready [NUM_EVENTS+1];
    stage_t node_stage [NUM_EVENTS+1];
    stage_t entry_stage;
    stage_t last_stage;
    logic   last_valid;
    logic   last_ready;

    assign count_ext = {1'b0, event_count_reg};
    assign count_sat = (count_ext > CNT_W'(NUM_EVENTS)) ? CNT_W'(NUM_EVENTS) : count_ext;

    always_comb
    begin
        entry_stage.tick = 1'b0;
        entry_stage.now  = item.time_of_day;
        entry_stage.day  = item.weekday;
        entry_stage.dep  = item.dependent_on;
        entry_stage.op   = OP_KEEP;
        entry_stage.val  = 1'b0;
        unique case (cmd_t'(item.command))
            CMD_TICK:
            begin
                entry_stage.tick = !suspend_reg;
                if (!suspend_reg && follow_reg && count_sat == '0)
                begin
                    entry_stage.op  = OP_SET;
                    entry_stage.val = item.dependent_on;
                end
            end
            CMD_ON:
            begin
                entry_stage.op  = OP_SET;
                entry_stage.val = 1'b1;
            end
            CMD_OFF:
            begin
                entry_stage.op  = OP_SET;
                entry_stage.val = 1'b0;
            end
            CMD_TOGGLE:
            begin
                entry_stage.op = OP_INVERT;
            end
        endcase
    end

    assign node_valid[0] = item.valid;
    assign node_stage[0] = entry_stage;
    assign item.ready    = node_ready[0];

    for (genvar i = 0; i < NUM_EVENTS; i++)
    begin : g_cell
        logic      ev_we;
        cell_ctl_t ctl;

        if (i < EVENT_REGS)
        begin : g_we
            assign ev_we = write_enable && (reg_index == REG_EVENT_A + CFG_IDX_W'(i));
        end
        else
        begin : g_no_we
            assign ev_we = 1'b0;
        end

        assign ctl.enable = CNT_W'(i) < count_sat;
        assign ctl.follow = follow_reg;

        wsr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (node_valid[i]),
            .in_ready  (node_ready[i]),
            .in_stage  (node_stage[i]),
            .out_valid (node_valid[i+1]),
            .out_ready (node_ready[i+1]),
            .out_stage (node_stage[i+1]),
            .ev_we     (ev_we),
            .ev_data   (write_data),
            .ctl       (ctl)
        );
    end

    assign last_valid             = node_valid[NUM_EVENTS];
    assign last_stage             = node_stage[NUM_EVENTS];
    assign last_ready             = !out_valid_reg || result.ready;
    assign node_ready[NUM_EVENTS] = last_ready;

    always_comb
    begin
        relay_state_next = relay_state_reg;
        if (last_valid && last_ready)
        begin
            unique case (last_stage.op)
                OP_SET:    relay_state_next = last_stage.val;
                OP_INVERT: relay_state_next = !relay_state_reg;
                default:   relay_state_next = relay_state_reg;
            endcase
        end
    end

    assign out_valid_next  = last_ready ? last_valid : out_valid_reg;
    assign result.valid    = out_valid_reg;
    assign result.relay_on = relay_state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_count_reg <= '0;
            follow_reg      <= 1'b0;
            suspend_reg     <= 1'b0;
            relay_state_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            relay_state_reg <= relay_state_next;
            out_valid_reg   <= out_valid_next;
            if (write_enable)
            begin
                unique case (reg_index)
                    REG_EVENT_COUNT: event_count_reg <= write_data[2:0];
                    REG_FOLLOW:      follow_reg      <= write_data[0];
                    REG_SUSPEND:     suspend_reg     <= write_data[0];
                    default: ;
                endcase
            end
        end
    end

    `WSR_ASSERT_NEXT(a_relay_held_on_stall, out_valid_reg && !result.ready,
        out_valid_reg && $stable(relay_state_reg))
    `WSR_ASSERT_NEXT(a_set_applied, last_valid && last_ready && last_stage.op == OP_SET,
        relay_state_reg == $past(last_stage.val))
    `WSR_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, last_ready)

endmodule

// ===== tb/tb_weekly_scheduled_relay.sv =====
// Testbench of the weekly scheduled relay: directed and random command words checked against a predictor.
module tb_weekly_scheduled_relay;
    timeunit 1ns;
    timeprecision 1ps;

    import wsr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_EVENT_B = REG_EVENT_A + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_C = REG_EVENT_A + 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_D = REG_EVENT_A + 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PHASES = 14;
    localparam int WORDS_PER_PHASE = 100;

    logic                  clk;
    logic                  rst_n;
    logic                  write_enable;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] write_data;

    wsr_in_if  cmd_ch ();
    wsr_out_if relay_ch ();

    weekly_scheduled_relay uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (cmd_ch),
        .result       (relay_ch),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data)
    );

    logic [EVENT_W-1:0] ev_regs [NUM_EVENTS] = '{default: '0};
    logic [2:0]         ev_count    = '0;
    logic               follow_mode = 1'b0;
    logic               suspended   = 1'b0;
    logic               relay_level = 1'b0;

    logic expected_levels [$];
    int   mismatch_count = 0;
    int   checked_count  = 0;
    int   cycle_count    = 0;
    bit   idle_on        = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [EVENT_W-1:0] pack_event(logic [16:0] start, logic [16:0] dur,
                                                      logic [6:0] days);
        return {days, dur, start};
    endfunction

    function automatic void apply_event(logic [EVENT_W-1:0] ev, logic [16:0] now,
                                        logic [2:0] day, logic dep);
        int unsigned start;
        int unsigned stop;
        logic [6:0]  days;
        bit          wrapped;
        bit          in_window;
        start   = ev[16:0];
        stop    = start + ev[33:17];
        days    = ev[40:34];
        wrapped = 1'b0;
        if (day > 3'd6 || !days[day])
            return;
        if (stop >= DAY_SECONDS)
        begin
            stop    = stop - DAY_SECONDS;
            wrapped = 1'b1;
        end
        if (follow_mode)
        begin
            if (wrapped)
                in_window = (now >= start) || (now <= stop);
            else
                in_window = (now >= start) && (now <= stop);
            relay_level = in_window ? dep : 1'b0;
        end
        else if (now == start)
            relay_level = 1'b1;
        else if (now == stop)
            relay_level = 1'b0;
    endfunction

    function automatic logic next_relay_level(cmd_t cmd, logic [16:0] now, logic [2:0] day,
                                              logic dep);
        int unsigned used;
        used = (ev_count > NUM_EVENTS) ? NUM_EVENTS : ev_count;
        case (cmd)
            CMD_ON:     relay_level = 1'b1;
            CMD_OFF:    relay_level = 1'b0;
            CMD_TOGGLE: relay_level = ~relay_level;
            default:
            begin
                if (!suspended)
                begin
                    if (used == 0 && follow_mode)
                        relay_level = dep;
                    for (int i = 0; i < used; i++)
                        apply_event(ev_regs[i], now, day, dep);
                end
            end
        endcase
        return relay_level;
    endfunction

    function automatic logic [EVENT_W-1:0] random_event();
        logic [16:0] start;
        logic [16:0] dur;
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        start = 17'($urandom_range(0, DAY_SECONDS - 1));
        case ($urandom_range(0, 4))
            0:       dur = 17'($urandom_range(0, 600));
            1:       dur = 17'($urandom_range(0, DAY_SECONDS - 1));
            2:       dur = 17'(DAY_SECONDS - start);
            3:       dur = 17'($urandom_range(0, 131071));
            default:
            begin
                start = 17'($urandom_range(0, 131071));
                dur   = 17'($urandom_range(0, 3600));
            end
        endcase
        return pack_event(start, dur, 7'($urandom_range(0, 127)));
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        write_enable <= 1'b1;
        reg_index    <= idx;
        write_data   <= data;
        @(posedge clk);
        write_enable <= 1'b0;
        case (idx)
            REG_EVENT_A, REG_EVENT_B, REG_EVENT_C, REG_EVENT_D: ev_regs[idx[1:0]] = data;
            REG_EVENT_COUNT: ev_count    = data[2:0];
            REG_FOLLOW:      follow_mode = data[0];
            REG_SUSPEND:     suspended   = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_word(cmd_t cmd, logic [16:0] now, logic [2:0] day, logic dep);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= cmd;
        cmd_ch.time_of_day  <= now;
        cmd_ch.weekday      <= day;
        cmd_ch.dependent_on <= dep;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        expected_levels.push_back(next_relay_level(cmd, now, day, dep));
    endtask

    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (NUM_EVENTS + 1) @(posedge clk);
    endtask

    task automatic test_switch_commands();
        send_word(CMD_ON, 17'd131071, 3'd7, 1'b0);
        send_word(CMD_TOGGLE, 17'd0, 3'd0, 1'b1);
        send_word(CMD_TOGGLE, 17'd86399, 3'd6, 1'b0);
        send_word(CMD_OFF, 17'd0, 3'd0, 1'b1);
        send_word(CMD_TICK, 17'd0, 3'd0, 1'b1);
    endtask

    task automatic test_follow_without_events();
        wait_idle();
        write_reg(REG_FOLLOW, 41'd1);
        send_word(CMD_TICK, 17'd131071, 3'd7, 1'b1);
        send_word(CMD_TICK, 17'd0, 3'd0, 1'b0);
    endtask

    task automatic test_wrapped_window();
        wait_idle();
        write_reg(REG_EVENT_A, pack_event(17'd86000, 17'd400, 7'h7F));
        write_reg(REG_EVENT_B, '0);
        write_reg(REG_EVENT_C, '0);
        write_reg(REG_EVENT_D, '0);
        write_reg(REG_EVENT_COUNT, 41'd7);
        write_reg(REG_UNUSED, '1);
        write_reg(REG_FOLLOW, 41'd1);
        send_word(CMD_TICK, 17'd86399, 3'd0, 1'b1);
        send_word(CMD_TICK, 17'd0, 3'd6, 1'b1);
        send_word(CMD_TICK, 17'd1, 3'd6, 1'b1);
        send_word(CMD_TICK, 17'd86200, 3'd3, 1'b1);
        send_word(CMD_TICK, 17'd43000, 3'd7, 1'b0);
        wait_idle();
        write_reg(REG_EVENT_B, pack_event(17'd131071, 17'd131071, 7'h40));
        write_reg(REG_EVENT_COUNT, 41'd2);
        send_word(CMD_TICK, 17'd131071, 3'd6, 1'b1);
        send_word(CMD_TICK, 17'd50000, 3'd6, 1'b1);
    endtask

    task automatic test_start_and_end_edges();
        wait_idle();
        write_reg(REG_FOLLOW, 41'd0);
        write_reg(REG_EVENT_A, pack_event(17'd100, 17'd50, 7'h7F));
        write_reg(REG_EVENT_B, pack_event(17'd86399, 17'd1, 7'h08));
        write_reg(REG_EVENT_C, '0);
        write_reg(REG_EVENT_D, '1);
        write_reg(REG_EVENT_COUNT, 41'd4);
        send_word(CMD_TICK, 17'd99, 3'd1, 1'b0);
        send_word(CMD_TICK, 17'd100, 3'd1, 1'b0);
        send_word(CMD_TICK, 17'd150, 3'd1, 1'b1);
        send_word(CMD_TICK, 17'd86399, 3'd3, 1'b0);
        send_word(CMD_TICK, 17'd0, 3'd3, 1'b1);
        send_word(CMD_TICK, 17'd86400, 3'd3, 1'b1);
        send_word(CMD_TICK, 17'd131071, 3'd2, 1'b0);
    endtask

    task automatic test_suspend();
        wait_idle();
        write_reg(REG_SUSPEND, 41'd1);
        send_word(CMD_OFF, 17'd0, 3'd0, 1'b0);
        send_word(CMD_TICK, 17'd100, 3'd1, 1'b1);
        send_word(CMD_ON, 17'd0, 3'd0, 1'b0);
        send_word(CMD_TICK, 17'd150, 3'd1, 1'b0);
        send_word(CMD_TOGGLE, 17'd0, 3'd0, 1'b0);
    endtask

    task automatic test_random_schedules();
        logic [EVENT_W-1:0] noise;
        logic [EVENT_W-1:0] ev;
        logic [2:0]         cnt;
        logic [16:0]        now;
        int unsigned        roll;
        int unsigned        start;
        int unsigned        stop;
        cmd_t               cmd;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            idle_on = (phase % 4) != 3;
            write_reg(REG_EVENT_A, random_event());
            write_reg(REG_EVENT_B, random_event());
            write_reg(REG_EVENT_C, random_event());
            write_reg(REG_EVENT_D, random_event());
            roll = $urandom_range(0, 9);
            if (roll == 0)
                cnt = 3'd0;
            else if (roll == 1)
                cnt = 3'($urandom_range(5, 7));
            else
                cnt = 3'($urandom_range(1, 4));
            noise = EVENT_W'({$urandom(), $urandom()});
            write_reg(REG_EVENT_COUNT, {noise[EVENT_W-1:3], cnt});
            noise = EVENT_W'({$urandom(), $urandom()});
            write_reg(REG_FOLLOW, {noise[EVENT_W-1:1], 1'($urandom_range(0, 1))});
            noise = EVENT_W'({$urandom(), $urandom()});
            write_reg(REG_SUSPEND, {noise[EVENT_W-1:1], $urandom_range(0, 9) == 0});
            if (phase % 5 == 0)
                write_reg(REG_UNUSED, noise);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                ev    = ev_regs[$urandom_range(0, NUM_EVENTS - 1)];
                start = ev[16:0];
                stop  = start + ev[33:17];
                if (stop >= DAY_SECONDS)
                    stop = stop - DAY_SECONDS;
                case ($urandom_range(0, 9))
                    0, 1:    now = 17'(start);
                    2, 3:    now = 17'(stop);
                    4:       now = 17'(start - 1);
                    5:       now = 17'(stop + 1);
                    6, 7:    now = 17'($urandom_range(0, DAY_SECONDS - 1));
                    8:       now = 17'($urandom_range(0, 131071));
                    default: now = 17'($urandom_range(DAY_SECONDS, 131071));
                endcase
                roll = $urandom_range(0, 99);
                if (roll < 75)
                    cmd = CMD_TICK;
                else if (roll < 83)
                    cmd = CMD_ON;
                else if (roll < 91)
                    cmd = CMD_OFF;
                else
                    cmd = CMD_TOGGLE;
                send_word(cmd, now,
                          ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6)),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        int stall_left;
        logic want;
        stall_left = 0;
        relay_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && relay_ch.valid && relay_ch.ready)
            begin
                if (expected_levels.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("word %0d: relay level %b with nothing expected",
                                 checked_count, relay_ch.relay_on);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (relay_ch.relay_on !== want)
                    begin
                        if (mismatch_count < 10)
                            $display("word %0d: relay level expected %b actual %b",
                                     checked_count, want, relay_ch.relay_on);
                        mismatch_count++;
                    end
                end
                checked_count++;
            end
            if (stall_left > 0)
            begin
                relay_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                relay_ch.ready <= 1'b1;
                if (idle_on)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n               <= 1'b0;
        write_enable        <= 1'b0;
        reg_index           <= '0;
        write_data          <= '0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.command      <= CMD_TICK;
        cmd_ch.time_of_day  <= '0;
        cmd_ch.weekday      <= '0;
        cmd_ch.dependent_on <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_switch_commands();
        test_follow_without_events();
        test_wrapped_window();
        test_start_and_end_edges();
        test_suspend();
        test_random_schedules();
        wait_idle();
        repeat (NUM_EVENTS + 2) @(posedge clk);
        if (mismatch_count == 0 && expected_levels.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
